/* rtl/core/bia_pkg.sv */
// shared types and constants of the bitmap block allocator
package bia_pkg;

    localparam int MAX_BLOCKS_DEF      = 1024;
    localparam int MAX_DATA_BLOCKS_DEF = 63;

    // free map is held as rows of this many blocks
    localparam int WORD_BITS = 32;
    localparam int WORD_LOG2 = 5;

    localparam int SIZE_W  = 20;
    localparam int LOG2_W  = 4;
    localparam int LIMIT_W = 11;
    localparam int BLK_W   = 10;
    localparam int FREE_W  = 11;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE_LOG2 = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BLOCKS_IN_USE   = 1'b1;

    localparam logic [LOG2_W-1:0]  LOG2_RESET   = 4'd6;
    localparam logic [LIMIT_W-1:0] IN_USE_RESET = 11'd1024;
    localparam logic [LOG2_W-1:0]  LOG2_MIN     = 4'd4;
    localparam logic [LOG2_W-1:0]  LOG2_MAX     = 4'd12;

    typedef struct packed {
        logic [LOG2_W-1:0]  block_size_log2;
        logic [LIMIT_W-1:0] blocks_in_use;
    } cfg_t;

endpackage

/* rtl/core/bia_if.sv */
// request and result channel interfaces
interface bia_req_if import bia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] file_size_bytes;

    modport source (output valid, output file_size_bytes, input ready);
    modport sink   (input valid, input file_size_bytes, output ready);
endinterface

interface bia_rsp_if import bia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [BLK_W-1:0]  block_number;
    logic              is_index_block;
    logic [FREE_W-1:0] free_after;
    logic              last_of_run;

    modport source (output valid, output granted, output block_number, output is_index_block,
                    output free_after, output last_of_run, input ready);
    modport sink   (input valid, input granted, input block_number, input is_index_block,
                    input free_after, input last_of_run, output ready);
endinterface

/* rtl/core/bia_front.sv */
// request intake: rounds the file size to whole blocks and flags oversize files
module bia_front import bia_pkg::*; #(
    parameter int MAX_DATA_BLOCKS = MAX_DATA_BLOCKS_DEF,
    parameter int DCW             = 6
) (
    input  cfg_t           cfg,
    input  logic           init_done,
    input  logic           q_full,
    bia_req_if.sink        req,
    output logic           push,
    output logic [DCW:0]   push_data
);

    logic [LOG2_W-1:0] lg;
    logic [SIZE_W:0]   round_mask;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W:0]   data_cnt;
    logic              too_many;

    always_comb
    begin
        if (cfg.block_size_log2 < LOG2_MIN)
            lg = LOG2_MIN;
        else if (cfg.block_size_log2 > LOG2_MAX)
            lg = LOG2_MAX;
        else
            lg = cfg.block_size_log2;
    end

    assign round_mask = ((SIZE_W+1)'(1) << lg) - (SIZE_W+1)'(1);
    assign size_sum   = {1'b0, req.file_size_bytes} + round_mask;
    assign data_cnt   = size_sum >> lg;
    assign too_many   = data_cnt > (SIZE_W+1)'(MAX_DATA_BLOCKS);

    assign req.ready = init_done && !q_full;
    assign push      = req.valid && req.ready;
    assign push_data = {too_many, data_cnt[DCW-1:0]};

endmodule

/* rtl/core/bia_queue.sv */
// two-entry job queue between intake and allocation
module bia_queue #(
    parameter int W = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] data
);

    logic [W-1:0] entry_reg [2];
    logic         wptr_reg;
    logic         rptr_reg;
    logic [1:0]   count_reg;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign data  = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                entry_reg[wptr_reg] <= push_data;
                wptr_reg            <= !wptr_reg;
            end
            if (pop)
                rptr_reg <= !rptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* rtl/core/bia_back.sv */
// allocation engine: counts free blocks, then marks and emits them first-fit, or emits a denial
module bia_back import bia_pkg::*; #(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int DCW        = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         job_valid,
    input  logic [DCW:0] job_data,
    output logic         job_pop,
    output logic         init_done,
    bia_rsp_if.source    rsp
);

    localparam int NWORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = AW + WORD_LOG2;
    localparam int CW     = ((BW > LIMIT_W) ? BW : LIMIT_W) + 2;
    localparam logic [AW:0] LAST_WORD = (AW+1)'(NWORDS - 1);
    localparam logic [AW:0] END_WORD  = (AW+1)'(NWORDS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_SCAN
    } state_t;

    state_t                state_reg, state_next;
    logic [AW:0]           waddr_reg, waddr_next;
    logic [AW-1:0]         cnt_addr_reg, cnt_addr_next;
    logic                  cnt_vld_reg, cnt_vld_next;
    logic [DCW:0]          job_reg, job_next;
    logic [FREE_W-1:0]     free_reg, free_next;
    logic [DCW:0]          rem_reg, rem_next;
    logic                  first_reg, first_next;
    logic                  fresh_reg, fresh_next;
    logic [WORD_BITS-1:0]  cur_reg, cur_next;
    logic [WORD_BITS-1:0]  rd_data_reg;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  granted_reg, granted_next;
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic                  index_reg, index_next;
    logic [FREE_W-1:0]     free_after_reg, free_after_next;
    logic                  last_reg, last_next;

    logic [WORD_BITS-1:0]  mem [NWORDS];
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0]  mem_wdata;

    logic [CW-1:0]         limit;
    logic                  slot_free;
    logic [WORD_BITS-1:0]  word_v, avail, lowest, cnt_avail;
    logic [WORD_LOG2-1:0]  bitpos;
    logic [AW:0]           waddr_inc;
    logic [BW-1:0]         blk_full;
    logic [BW+BLK_W-1:0]   blk_wide;
    logic [DCW+1:0]        need;
    logic                  grant;

    function automatic logic [WORD_BITS-1:0] word_mask(input logic [AW-1:0] w,
                                                       input logic [CW-1:0] lim);
        logic [CW-1:0]        base;
        logic [CW-1:0]        diff;
        logic [WORD_BITS-1:0] m;
        base = CW'(w) << WORD_LOG2;
        diff = lim - base;
        if (base >= lim)
            m = '0;
        else if (diff >= CW'(WORD_BITS))
            m = '1;
        else
            m = (WORD_BITS'(1) << diff[WORD_LOG2-1:0]) - WORD_BITS'(1);
        return m;
    endfunction

    // allocatable range, clamped to at least one block and the map size
    always_comb
    begin
        if (cfg.blocks_in_use == '0)
            limit = CW'(1);
        else if (CW'(cfg.blocks_in_use) > CW'(MAX_BLOCKS))
            limit = CW'(MAX_BLOCKS);
        else
            limit = CW'(cfg.blocks_in_use);
    end

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign word_v    = fresh_reg ? rd_data_reg : cur_reg;
    assign avail     = ~word_v & word_mask(waddr_reg[AW-1:0], limit);
    assign lowest    = avail & (~avail + WORD_BITS'(1));
    assign cnt_avail = ~rd_data_reg & word_mask(cnt_addr_reg, limit);
    assign waddr_inc = waddr_reg + (AW+1)'(1);
    assign blk_full  = {waddr_reg[AW-1:0], bitpos};
    assign blk_wide  = {{BLK_W{1'b0}}, blk_full};
    assign need      = (DCW+2)'(job_reg[DCW-1:0]) + (DCW+2)'(1);
    assign grant     = !job_reg[DCW] &&
                       ((DCW+FREE_W+2)'(free_reg) >= (DCW+FREE_W+2)'(need));
    assign init_done = state_reg != ST_CLEAR;

    always_comb
    begin
        bitpos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest[i])
                bitpos = bitpos | WORD_LOG2'(i);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        waddr_next      = waddr_reg;
        cnt_addr_next   = cnt_addr_reg;
        cnt_vld_next    = cnt_vld_reg;
        job_next        = job_reg;
        free_next       = free_reg;
        rem_next        = rem_reg;
        first_next      = first_reg;
        fresh_next      = fresh_reg;
        cur_next        = cur_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        granted_next    = granted_reg;
        blk_next        = blk_reg;
        index_next      = index_reg;
        free_after_next = free_after_reg;
        last_next       = last_reg;
        job_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = waddr_reg[AW-1:0];
        mem_raddr       = waddr_reg[AW-1:0];
        mem_wdata       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (waddr_reg == LAST_WORD)
                begin
                    waddr_next = '0;
                    state_next = ST_IDLE;
                end
                else
                    waddr_next = waddr_inc;
            end
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop      = 1'b1;
                    job_next     = job_data;
                    waddr_next   = '0;
                    free_next    = '0;
                    cnt_vld_next = 1'b0;
                    state_next   = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                // read one row a cycle, count the row read the cycle before
                if (cnt_vld_reg)
                    free_next = free_reg + FREE_W'($countones(cnt_avail));
                if (waddr_reg != END_WORD)
                begin
                    mem_re        = 1'b1;
                    cnt_addr_next = waddr_reg[AW-1:0];
                    cnt_vld_next  = 1'b1;
                    waddr_next    = waddr_inc;
                end
                else
                begin
                    cnt_vld_next = 1'b0;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!grant)
                begin
                    if (slot_free)
                    begin
                        rsp_valid_next  = 1'b1;
                        granted_next    = 1'b0;
                        blk_next        = '0;
                        index_next      = 1'b0;
                        free_after_next = free_reg;
                        last_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    rem_next   = need[DCW:0];
                    first_next = 1'b1;
                    waddr_next = '0;
                    mem_re     = 1'b1;
                    mem_raddr  = '0;
                    fresh_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cur_next   = word_v;
                fresh_next = 1'b0;
                if (avail == '0)
                begin
                    waddr_next = waddr_inc;
                    mem_re     = 1'b1;
                    mem_raddr  = waddr_inc[AW-1:0];
                    fresh_next = 1'b1;
                end
                else if (slot_free)
                begin
                    mem_we          = 1'b1;
                    mem_wdata       = word_v | lowest;
                    cur_next        = word_v | lowest;
                    rsp_valid_next  = 1'b1;
                    granted_next    = 1'b1;
                    blk_next        = blk_wide[BLK_W-1:0];
                    index_next      = first_reg;
                    free_after_next = free_reg - FREE_W'(1);
                    last_next       = rem_reg == (DCW+1)'(1);
                    free_next       = free_reg - FREE_W'(1);
                    rem_next        = rem_reg - (DCW+1)'(1);
                    first_next      = 1'b0;
                    if (rem_reg == (DCW+1)'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            waddr_reg      <= '0;
            cnt_addr_reg   <= '0;
            cnt_vld_reg    <= 1'b0;
            job_reg        <= '0;
            free_reg       <= '0;
            rem_reg        <= '0;
            first_reg      <= 1'b0;
            fresh_reg      <= 1'b0;
            cur_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            granted_reg    <= 1'b0;
            blk_reg        <= '0;
            index_reg      <= 1'b0;
            free_after_reg <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            waddr_reg      <= waddr_next;
            cnt_addr_reg   <= cnt_addr_next;
            cnt_vld_reg    <= cnt_vld_next;
            job_reg        <= job_next;
            free_reg       <= free_next;
            rem_reg        <= rem_next;
            first_reg      <= first_next;
            fresh_reg      <= fresh_next;
            cur_reg        <= cur_next;
            rsp_valid_reg  <= rsp_valid_next;
            granted_reg    <= granted_next;
            blk_reg        <= blk_next;
            index_reg      <= index_next;
            free_after_reg <= free_after_next;
            last_reg       <= last_next;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.granted        = granted_reg;
    assign rsp.block_number   = blk_reg;
    assign rsp.is_index_block = index_reg;
    assign rsp.free_after     = free_after_reg;
    assign rsp.last_of_run    = last_reg;

    // a granted run never outlasts its free count or its block budget
    a_scan_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> rem_reg != '0 && free_reg != '0)
        else $error("scan with exhausted budget");

    // the scan never walks off the end of the map
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> waddr_reg < END_WORD)
        else $error("scan past last row");

    // nothing is taken or emitted before the clearing pass ends
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !job_pop && !rsp_valid_reg)
        else $error("activity during clearing pass");

    // a denial is always a single closing word with no block
    a_deny_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !granted_reg |-> last_reg && blk_reg == '0 && !index_reg)
        else $error("malformed denial");

endmodule

/* rtl/core/bitmap_indexed_block_allocator.sv */
// top level of the first-fit bitmap block allocator
//
//  channel  role    handshake        word
//  req      sink    valid / ready    file_size_bytes
//  rsp      source  valid / ready    granted, block_number, is_index_block,
//                                    free_after, last_of_run
//  apb      slave   psel / penable   block_size_log2 at 0x0, blocks_in_use at 0x4
//
//  a request first counts free blocks, one 32-block row per cycle through the
//  single read port of the map, then scans the map first-fit, marking and
//  emitting each granted block and moving on a row when the current one has
//  no free block left; after reset the map is cleared one row a cycle and
//  req.ready stays low until that pass ends
//  the two-entry job queue lets intake run ahead of allocation; results sit
//  in an output register so a stalled rsp holds the allocation engine, and
//  intake too once the job queue is full
module bitmap_indexed_block_allocator import bia_pkg::*; #(
    parameter int MAX_BLOCKS      = MAX_BLOCKS_DEF,
    parameter int MAX_DATA_BLOCKS = MAX_DATA_BLOCKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bia_req_if.sink            req,
    bia_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // width of a data block count that passed the per-file limit
    localparam int DCW = (MAX_DATA_BLOCKS > 1) ? $clog2(MAX_DATA_BLOCKS + 1) : 1;

    logic [LOG2_W-1:0]    log2_reg;
    logic [LIMIT_W-1:0]   in_use_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    cfg_t                 cfg;

    logic                 init_done;
    logic                 q_full;
    logic                 q_push;
    logic [DCW:0]         q_push_data;
    logic                 q_pop;
    logic                 q_valid;
    logic [DCW:0]         q_data;

    // register file, word-aligned, low address bits ignored
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg   <= LOG2_RESET;
            in_use_reg <= IN_USE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_BLOCK_SIZE_LOG2: log2_reg   <= pwdata[LOG2_W-1:0];
                REG_BLOCKS_IN_USE:   in_use_reg <= pwdata[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BLOCK_SIZE_LOG2: prdata = PDATA_W'(log2_reg);
            REG_BLOCKS_IN_USE:   prdata = PDATA_W'(in_use_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.block_size_log2 = log2_reg;
    assign cfg.blocks_in_use   = in_use_reg;

    // intake: size to block count, oversize check
    bia_front #(
        .MAX_DATA_BLOCKS (MAX_DATA_BLOCKS),
        .DCW             (DCW)
    ) u_front (
        .cfg       (cfg),
        .init_done (init_done),
        .q_full    (q_full),
        .req       (req),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // short decoupling queue
    bia_queue #(
        .W (DCW + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    // free map, counting and first-fit marking
    bia_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .DCW        (DCW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (q_valid),
        .job_data  (q_data),
        .job_pop   (q_pop),
        .init_done (init_done),
        .rsp       (rsp)
    );

endmodule

/* bench/tb_bitmap_indexed_block_allocator.sv */
// self-checking testbench for the first-fit bitmap block allocator
`timescale 1ns / 100ps

module tb_bitmap_indexed_block_allocator;
    import bia_pkg::*;

    // worst quiet stretch of a correct run: clearing pass plus reset, the long
    // result hold, one slow request and a sender pause on top; the limit is
    // several times that
    localparam int QUIET_LIMIT     = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int TAIL_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 49;
    localparam int RANDOM_PHASES   = 8;

    typedef struct packed {
        logic              granted;
        logic [BLK_W-1:0]  block_number;
        logic              is_index_block;
        logic [FREE_W-1:0] free_after;
        logic              last_of_run;
    } alloc_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // request side, driven at the falling edge
    logic              offer_valid = 1'b0;
    logic [SIZE_W-1:0] offer_size  = '0;
    logic              take_ready  = 1'b0;

    // register port
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bia_req_if req_ch ();
    bia_rsp_if rsp_ch ();

    assign req_ch.valid           = offer_valid;
    assign req_ch.file_size_bytes = offer_size;
    assign rsp_ch.ready           = take_ready;

    bitmap_indexed_block_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // file sizes waiting to be offered, and block words still owed by the block
    logic [SIZE_W-1:0] pending_sizes [$];
    alloc_word_t       grants_due [$];

    // private copy of the allocator state and its two registers
    bit [MAX_BLOCKS_DEF-1:0] block_used  = '0;
    logic [LOG2_W-1:0]       cfg_log2    = LOG2_RESET;
    logic [LIMIT_W-1:0]      cfg_in_use  = IN_USE_RESET;

    logic        req_taken     = 1'b0;
    logic        idle_on       = 1'b1;
    logic        long_hold_req = 1'b0;
    int unsigned send_gap      = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned fail_count    = 0;
    int unsigned n_requests    = 0;
    int unsigned n_blocks      = 0;
    int unsigned n_denials     = 0;
    int unsigned n_cfg_writes  = 0;
    alloc_word_t want;

    // block size as the block uses it, clamped to 16 bytes .. 4 KiB
    function automatic int unsigned eff_log2();
        if (cfg_log2 < LOG2_MIN)
            return LOG2_MIN;
        if (cfg_log2 > LOG2_MAX)
            return LOG2_MAX;
        return cfg_log2;
    endfunction

    // works out the block words one request causes and marks the map
    function automatic void predict_allocation(input logic [SIZE_W-1:0] size);
        int unsigned lg;
        int unsigned lim;
        int unsigned n_data;
        int unsigned n_free;
        int unsigned slot;
        int unsigned i;
        alloc_word_t w;
        lg = eff_log2();
        if (cfg_in_use == 0)
            lim = 1;
        else if (cfg_in_use > MAX_BLOCKS_DEF)
            lim = MAX_BLOCKS_DEF;
        else
            lim = cfg_in_use;
        // round up to whole blocks
        n_data = (size + (32'd1 << lg) - 1) >> lg;
        n_free = 0;
        for (i = 0; i < lim; i++)
            if (!block_used[i])
                n_free++;
        // marked blocks above a shrunk range are neither free nor taken
        if (n_data > MAX_DATA_BLOCKS_DEF || n_free < n_data + 1) begin
            w.granted        = 1'b0;
            w.block_number   = '0;
            w.is_index_block = 1'b0;
            w.free_after     = n_free[FREE_W-1:0];
            w.last_of_run    = 1'b1;
            grants_due.push_back(w);
            return;
        end
        // index block first, then each data block, lowest free first
        for (i = 0; i <= n_data; i++) begin
            slot = 0;
            while (block_used[slot])
                slot++;
            block_used[slot] = 1'b1;
            n_free--;
            w.granted        = 1'b1;
            w.block_number   = slot[BLK_W-1:0];
            w.is_index_block = (i == 0);
            w.free_after     = n_free[FREE_W-1:0];
            w.last_of_run    = (i == n_data);
            grants_due.push_back(w);
        end
    endfunction

    // sizes are drawn as a block count for the current block size, so most
    // requests fit; a few are zero, one over the data limit, or anything at all
    function automatic logic [SIZE_W-1:0] random_file_size();
        int unsigned lg;
        int unsigned pick;
        int unsigned n;
        lg = eff_log2();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick >= 96)
            return SIZE_W'($urandom);
        if (pick < 45)
            n = $urandom_range(1, 2);
        else if (pick < 80)
            n = $urandom_range(3, 6);
        else if (pick < 90)
            n = $urandom_range(7, 20);
        else
            n = $urandom_range(21, MAX_DATA_BLOCKS_DEF + 1);
        return SIZE_W'(((n - 1) << lg) + $urandom_range(1, 1 << lg));
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // request intake: the word is taken here, so predict from it at once
    always @(posedge clk)
    begin
        if (rst_n && offer_valid && req_ch.ready) begin
            predict_allocation(offer_size);
            void'(pending_sizes.pop_front());
            n_requests++;
            req_taken <= 1'b1;
        end
        else
            req_taken <= 1'b0;
    end

    // sender: holds a word until it is taken, then may pause for a burst
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (req_taken && idle_on && $urandom_range(0, 4) == 0)
                send_gap = $urandom_range(1, 18);
            if (offer_valid && !req_taken) begin
                // word still on offer
            end
            else if (send_gap > 0) begin
                offer_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_sizes.size() != 0) begin
                offer_valid <= 1'b1;
                offer_size  <= pending_sizes[0];
            end
            else
                offer_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts, and one long hold so the job queue fills
    // and the block has to drop req.ready
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (hold_left > 0) begin
                take_ready <= 1'b0;
                hold_left--;
            end
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD - 1;
                take_ready    <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left  = $urandom_range(0, 17);
                take_ready <= 1'b0;
            end
            else
                take_ready <= 1'b1;
        end
    end

    // result checker: each word against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && take_ready) begin
            if (grants_due.size() == 0) begin
                $display("%0t: block word with nothing owed: granted %0b block %0d free %0d",
                         $time, rsp_ch.granted, rsp_ch.block_number, rsp_ch.free_after);
                fail_count++;
            end
            else begin
                want = grants_due.pop_front();
                check_field("granted", want.granted, rsp_ch.granted);
                check_field("block_number", want.block_number, rsp_ch.block_number);
                check_field("is_index_block", want.is_index_block, rsp_ch.is_index_block);
                check_field("free_after", want.free_after, rsp_ch.free_after);
                check_field("last_of_run", want.last_of_run, rsp_ch.last_of_run);
                if (rsp_ch.granted)
                    n_blocks++;
                else
                    n_denials++;
            end
        end
    end

    // watchdog on cycles where nothing moves on any port
    always @(posedge clk)
    begin
        if ((offer_valid && req_ch.ready) || (rsp_ch.valid && take_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d requests queued, %0d words owed",
                     $time, quiet_cycles, pending_sizes.size(), grants_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen high
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_BLOCK_SIZE_LOG2: cfg_log2   = value[LOG2_W-1:0];
            REG_BLOCKS_IN_USE:   cfg_in_use = value[LIMIT_W-1:0];
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // every request yields at least one word, so an empty store of owed
    // words with nothing queued means the block is idle
    task automatic wait_idle();
        while (pending_sizes.size() != 0 || grants_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned k;
        int unsigned pick;
        logic [PDATA_W-1:0] in_use_val;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset setting, 64-byte blocks over the whole store: empty file gives
        // the index block alone, block-size edges, the largest grant, one data
        // block over the limit, and the largest size
        pending_sizes = '{20'd0, 20'd1, 20'd63, 20'd64, 20'd65, 20'd4032, 20'd4033,
                          20'hFFFFF, 20'd128};
        wait_idle();

        // block size below range, taken as 16 bytes
        write_reg(REG_BLOCK_SIZE_LOG2, 32'd0);
        pending_sizes = '{20'd16, 20'd17, 20'd1008, 20'd1009};
        wait_idle();

        // block size above range, taken as 4 KiB
        write_reg(REG_BLOCK_SIZE_LOG2, 32'd15);
        pending_sizes = '{20'd4096, 20'd4097, 20'd258048, 20'd258049};
        wait_idle();

        // range of zero counts as one block, and block 0 is long gone
        write_reg(REG_BLOCKS_IN_USE, 32'd0);
        pending_sizes.push_back(20'd0);
        wait_idle();

        // shrunk range with 15 free: one request short of space, one that takes
        // exactly all of it, then an empty file against a full range
        write_reg(REG_BLOCKS_IN_USE, 32'd230);
        pending_sizes = '{20'd65536, 20'd57344, 20'd0};
        wait_idle();

        // widest range value, clamped to the whole store
        write_reg(REG_BLOCKS_IN_USE, 32'd2047);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase != 0) begin
                pick = $urandom_range(0, 7);
                if (pick < 2)
                    write_reg(REG_BLOCK_SIZE_LOG2, $urandom_range(0, 15));
                else
                    write_reg(REG_BLOCK_SIZE_LOG2, $urandom_range(LOG2_MIN, LOG2_MAX));
                pick = $urandom_range(0, 7);
                if (pick < 2)
                    in_use_val = 32'd2047;
                else if (pick < 4)
                    in_use_val = PDATA_W'(IN_USE_RESET);
                else if (pick == 4)
                    in_use_val = $urandom_range(0, 64);
                else
                    in_use_val = $urandom_range(700, 2047);
                write_reg(REG_BLOCKS_IN_USE, in_use_val);
            end
            // no idling at all in the closing phase
            if (phase == RANDOM_PHASES - 1)
                idle_on = 1'b0;
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                pending_sizes.push_back(random_file_size());
            if (phase == 0)
                long_hold_req = 1'b1;
            wait_idle();
        end

        // let any stray word show up before closing
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d file requests: %0d blocks granted, %0d denied, map filled to the limit",
                 n_requests, n_blocks, n_denials);
        $display("%0d register writes over clamped and in-range settings, one long result hold",
                 n_cfg_writes);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bia_pkg.sv
rtl/core/bia_if.sv
rtl/core/bia_front.sv
rtl/core/bia_queue.sv
rtl/core/bia_back.sv
rtl/core/bitmap_indexed_block_allocator.sv
bench/tb_bitmap_indexed_block_allocator.sv
